### design/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// Lane numbering and shared constants for the quaternion to rotation matrix
// pipeline. One lane per matrix entry, in column-major order.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int unsigned NUM_LANES = 9;

    typedef logic [NUM_LANES-1:0] t_lane_vec;

    localparam int unsigned LANE_00 = 0;
    localparam int unsigned LANE_10 = 1;
    localparam int unsigned LANE_20 = 2;
    localparam int unsigned LANE_01 = 3;
    localparam int unsigned LANE_11 = 4;
    localparam int unsigned LANE_21 = 5;
    localparam int unsigned LANE_02 = 6;
    localparam int unsigned LANE_12 = 7;
    localparam int unsigned LANE_22 = 8;

    // diagonal entries: 00, 11, 22
    localparam t_lane_vec DIAG_MASK = t_lane_vec'(9'b100010001);

endpackage

### design/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a quaternion (x, y, z, w) to its 3x3 rotation matrix in signed
// Q1.FRAC_BITS. Every entry is the exact ratio of a sum of products to the
// squared norm n, rounded to nearest (ties away from zero), so unnormalized
// quaternions still give a proper rotation. An all-zero quaternion gives the
// identity and raises o_zero_quat. The block takes one beat per cycle while
// the output is not stalled; each beat passes through one stage of products,
// one of pair sums, one of norm and magnitudes, FRAC_BITS + 1 stages of a
// restoring divider that resolves one quotient bit per stage in nine lanes,
// one rounding stage and the output register. Empty stages close up behind
// a stalled output, so new beats are taken until every stage holds one.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COMP_WIDTH-1:0]  i_quat_x,
    input  logic signed [COMP_WIDTH-1:0]  i_quat_y,
    input  logic signed [COMP_WIDTH-1:0]  i_quat_z,
    input  logic signed [COMP_WIDTH-1:0]  i_quat_w,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [FRAC_BITS+1:0]   o_rot_00,
    output logic signed [FRAC_BITS+1:0]   o_rot_10,
    output logic signed [FRAC_BITS+1:0]   o_rot_20,
    output logic signed [FRAC_BITS+1:0]   o_rot_01,
    output logic signed [FRAC_BITS+1:0]   o_rot_11,
    output logic signed [FRAC_BITS+1:0]   o_rot_21,
    output logic signed [FRAC_BITS+1:0]   o_rot_02,
    output logic signed [FRAC_BITS+1:0]   o_rot_12,
    output logic signed [FRAC_BITS+1:0]   o_rot_22,
    output logic                          o_zero_quat
);

    import qrm_pkg::*;

    localparam int PW         = 2 * COMP_WIDTH;
    localparam int SQW        = PW - 1;
    localparam int NW         = PW + 1;
    localparam int QW         = FRAC_BITS + 1;
    localparam int OW         = FRAC_BITS + 2;
    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int ST_PROD    = 0;
    localparam int ST_SUM     = 1;
    localparam int ST_MAG     = 2;
    localparam int ST_DIV0    = 3;
    localparam int ST_RND     = ST_DIV0 + DIV_STAGES;
    localparam int ST_OUT     = ST_RND + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    localparam logic [OW-1:0] ONE_Q = {2'b01, {FRAC_BITS{1'b0}}};

    function automatic logic [PW:0] sx(input logic [PW-1:0] a);
        return {a[PW-1], a};
    endfunction

    // {neg, magnitude} of a - b
    function automatic logic [NW:0] diag_mag(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic          ge;
        logic [PW-1:0] d;
        ge = (a >= b);
        d  = ge ? (a - b) : (b - a);
        return {~ge, 1'b0, d};
    endfunction

    // {neg, 2 * magnitude} of s
    function automatic logic [NW:0] off_mag(input logic [PW:0] s);
        logic [PW:0] m;
        m = s[PW] ? (-s) : s;
        return {s[PW], m[PW-1:0], 1'b0};
    endfunction

    // one restoring step: {quotient, remainder}
    function automatic logic [QW+NW-1:0] div_step(input logic [NW:0]   t,
                                                  input logic [NW-1:0] n,
                                                  input logic [QW-1:0] q_in);
        logic          ge;
        logic [NW:0]   d;
        logic [NW-1:0] rem;
        ge  = (t >= {1'b0, n});
        d   = t - {1'b0, n};
        rem = ge ? d[NW-1:0] : t[NW-1:0];
        return {q_in[QW-2:0], ge, rem};
    endfunction

    // ---------------- flow control ----------------
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_adv;

    // a stage moves when the output drains or it or any later stage is empty
    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            w_adv[k] = !i_stall ||
                !(&(r_vld | ((NUM_STAGES'(1) << k) - NUM_STAGES'(1))));
        end
    end

    assign n_vld = {r_vld[NUM_STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_stall = !w_adv[ST_PROD];
    assign o_valid = r_vld[ST_OUT];

    // ---------------- products ----------------
    logic signed [PW-1:0] w_sq_x, w_sq_y, w_sq_z, w_sq_w;
    logic [SQW-1:0]       r_xx, r_yy, r_zz, r_ww;
    logic signed [PW-1:0] r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;

    assign w_sq_x = i_quat_x * i_quat_x;
    assign w_sq_y = i_quat_y * i_quat_y;
    assign w_sq_z = i_quat_z * i_quat_z;
    assign w_sq_w = i_quat_w * i_quat_w;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_PROD]) begin
            r_xx <= w_sq_x[SQW-1:0];
            r_yy <= w_sq_y[SQW-1:0];
            r_zz <= w_sq_z[SQW-1:0];
            r_ww <= w_sq_w[SQW-1:0];
            r_xy <= i_quat_x * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;
            r_xz <= i_quat_x * i_quat_z;
            r_wy <= i_quat_w * i_quat_y;
            r_yz <= i_quat_y * i_quat_z;
            r_wx <= i_quat_w * i_quat_x;
        end
    end

    // ---------------- pair sums ----------------
    logic [PW-1:0] r_p_xw, r_p_yz, r_p_yw, r_p_zx, r_p_zw, r_p_xy;
    logic [PW:0]   r_s_10, r_s_20, r_s_01, r_s_21, r_s_02, r_s_12;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_SUM]) begin
            r_p_xw <= {1'b0, r_xx} + {1'b0, r_ww};
            r_p_yz <= {1'b0, r_yy} + {1'b0, r_zz};
            r_p_yw <= {1'b0, r_yy} + {1'b0, r_ww};
            r_p_zx <= {1'b0, r_zz} + {1'b0, r_xx};
            r_p_zw <= {1'b0, r_zz} + {1'b0, r_ww};
            r_p_xy <= {1'b0, r_xx} + {1'b0, r_yy};
            r_s_10 <= sx(r_xy) + sx(r_wz);
            r_s_20 <= sx(r_xz) - sx(r_wy);
            r_s_01 <= sx(r_xy) - sx(r_wz);
            r_s_21 <= sx(r_yz) + sx(r_wx);
            r_s_02 <= sx(r_wy) + sx(r_xz);
            r_s_12 <= sx(r_yz) - sx(r_wx);
        end
    end

    // ---------------- norm and numerators ----------------
    logic [NW:0]   n_mag [NUM_LANES];
    logic [NW-1:0] r_num [NUM_LANES];
    t_lane_vec     r_neg;
    logic [NW-1:0] r_n;
    logic          r_zero;

    always_comb begin
        n_mag[LANE_00] = diag_mag(r_p_xw, r_p_yz);
        n_mag[LANE_10] = off_mag(r_s_10);
        n_mag[LANE_20] = off_mag(r_s_20);
        n_mag[LANE_01] = off_mag(r_s_01);
        n_mag[LANE_11] = diag_mag(r_p_yw, r_p_zx);
        n_mag[LANE_21] = off_mag(r_s_21);
        n_mag[LANE_02] = off_mag(r_s_02);
        n_mag[LANE_12] = off_mag(r_s_12);
        n_mag[LANE_22] = diag_mag(r_p_zw, r_p_xy);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_MAG]) begin
            r_n    <= {1'b0, r_p_xw} + {1'b0, r_p_yz};
            r_zero <= (r_p_xw == '0) && (r_p_yz == '0);
            for (int l = 0; l < NUM_LANES; l++) begin
                r_num[l] <= n_mag[l][NW-1:0];
                r_neg[l] <= n_mag[l][NW];
            end
        end
    end

    // ---------------- divider, one quotient bit per stage ----------------
    logic [QW+NW-1:0] n_step [DIV_STAGES][NUM_LANES];
    t_lane_vec        n_dneg [DIV_STAGES];
    logic [NW-1:0]    n_dn   [DIV_STAGES];
    logic             n_dzero[DIV_STAGES];
    logic [NW-1:0]    r_rem  [DIV_STAGES][NUM_LANES];
    logic [QW-1:0]    r_q    [DIV_STAGES][NUM_LANES];
    t_lane_vec        r_dneg [DIV_STAGES];
    logic [NW-1:0]    r_dn   [DIV_STAGES];
    logic             r_dzero[DIV_STAGES];

    always_comb begin
        n_dneg[0]  = r_neg;
        n_dn[0]    = r_n;
        n_dzero[0] = r_zero;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_step[0][l] = div_step({1'b0, r_num[l]}, r_n, '0);
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            n_dneg[k]  = r_dneg[k-1];
            n_dn[k]    = r_dn[k-1];
            n_dzero[k] = r_dzero[k-1];
            for (int l = 0; l < NUM_LANES; l++) begin
                n_step[k][l] = div_step({r_rem[k-1][l], 1'b0}, r_dn[k-1], r_q[k-1][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (w_adv[ST_DIV0+k]) begin
                r_dneg[k]  <= n_dneg[k];
                r_dn[k]    <= n_dn[k];
                r_dzero[k] <= n_dzero[k];
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_q[k][l]   <= n_step[k][l][QW+NW-1:NW];
                    r_rem[k][l] <= n_step[k][l][NW-1:0];
                end
            end
        end
    end

    // ---------------- rounding decision ----------------
    logic [QW-1:0] r_rq [NUM_LANES];
    t_lane_vec     r_rb;
    t_lane_vec     r_rneg;
    logic          r_rzero;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_RND]) begin
            r_rneg  <= r_dneg[DIV_STAGES-1];
            r_rzero <= r_dzero[DIV_STAGES-1];
            for (int l = 0; l < NUM_LANES; l++) begin
                r_rq[l] <= r_q[DIV_STAGES-1][l];
                r_rb[l] <= {r_rem[DIV_STAGES-1][l], 1'b0} >= {1'b0, r_dn[DIV_STAGES-1]};
            end
        end
    end

    // ---------------- round, sign, output register ----------------
    logic [OW-1:0] n_rot [NUM_LANES];
    logic [OW-1:0] r_rot [NUM_LANES];
    logic          r_ozero;

    // -(q + rb) == ~q + !rb
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_rzero) begin
                n_rot[l] = DIAG_MASK[l] ? ONE_Q : '0;
            end else if (r_rneg[l]) begin
                n_rot[l] = ~{1'b0, r_rq[l]} + {{(OW-1){1'b0}}, !r_rb[l]};
            end else begin
                n_rot[l] = {1'b0, r_rq[l]} + {{(OW-1){1'b0}}, r_rb[l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_OUT]) begin
            r_ozero <= r_rzero;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_rot[l] <= n_rot[l];
            end
        end
    end

    assign o_rot_00    = r_rot[LANE_00];
    assign o_rot_10    = r_rot[LANE_10];
    assign o_rot_20    = r_rot[LANE_20];
    assign o_rot_01    = r_rot[LANE_01];
    assign o_rot_11    = r_rot[LANE_11];
    assign o_rot_21    = r_rot[LANE_21];
    assign o_rot_02    = r_rot[LANE_02];
    assign o_rot_12    = r_rot[LANE_12];
    assign o_rot_22    = r_rot[LANE_22];
    assign o_zero_quat = r_ozero;

endmodule
